FILE: design/sha256_pkg.sv
// Package: SHA-256 constants, functions and controller/datapath interface types.
`default_nettype none
package sha256_pkg;
   localparam int unsigned Rounds = 64;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_COMPRESS,
      ST_ADD,
      ST_EMIT
   } ctrl_state_type;

   typedef enum logic [1:0] {
      SRC_DATA,
      SRC_PAD80,
      SRC_ZERO,
      SRC_LEN
   } byte_src_type;

   typedef struct packed {
      logic         put_byte;
      byte_src_type src;
      logic         start_comp;
      logic         round_step;
      logic         add_hash;
      logic         count_bits;
      logic         restore_iv;
      logic         emit_shift;
   } dp_cmd_type;

   typedef struct packed {
      logic [6:0] fill;
      logic       round_last;
   } dp_status_type;

   function automatic logic [31:0] iv_word(input logic [2:0] idx);
      logic [31:0] v;
      case (idx)
         3'd0: v = 32'h6a09e667;
         3'd1: v = 32'hbb67ae85;
         3'd2: v = 32'h3c6ef372;
         3'd3: v = 32'ha54ff53a;
         3'd4: v = 32'h510e527f;
         3'd5: v = 32'h9b05688c;
         3'd6: v = 32'h1f83d9ab;
         default: v = 32'h5be0cd19;
      endcase
      return v;
   endfunction

   function automatic logic [31:0] round_const(input logic [5:0] idx);
      logic [31:0] k [0:63];
      k = '{
         32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
         32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
         32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
         32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
         32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
         32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
         32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
         32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
         32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
         32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
         32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      return k[idx];
   endfunction
endpackage
`default_nettype wire

FILE: design/sha256_dp.sv
// Datapath: block schedule shift line, round registers, hash words, bit count, digest output.
`default_nettype none
module sha256_dp (
   input  wire                        clock,
   input  wire                        reset,
   input  sha256_pkg::dp_cmd_type     cmd,
   input  wire  [7:0]                 data_byte,
   output sha256_pkg::dp_status_type  status,
   output logic [31:0]                digest_word
);
   import sha256_pkg::*;

   logic [31:0] w_ff [0:15];
   logic [31:0] w_in [0:15];
   logic [31:0] hash_ff [0:7];
   logic [31:0] hash_in [0:7];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff, f_ff, g_ff, h_ff;
   logic [31:0] a_in, b_in, c_in, d_in, e_in, f_in, g_in, h_in;
   logic [6:0]  fill_ff, fill_in;
   logic [5:0]  round_ff, round_in;
   logic [63:0] bits_ff, bits_in;
   logic [63:0] len_ff, len_in;
   logic [7:0]  byte_val;
   logic [31:0] sg0, sg1, big0, big1, chs, maj, t1, t2, w_new;

   always_comb begin
      case (cmd.src)
         SRC_DATA:  byte_val = data_byte;
         SRC_PAD80: byte_val = 8'h80;
         SRC_ZERO:  byte_val = 8'h00;
         SRC_LEN:   byte_val = len_ff[63:56];
         default:   byte_val = 8'h00;
      endcase
   end

   always_comb begin
      sg0  = {w_ff[1][6:0], w_ff[1][31:7]} ^ {w_ff[1][17:0], w_ff[1][31:18]} ^ (w_ff[1] >> 3);
      sg1  = {w_ff[14][16:0], w_ff[14][31:17]} ^ {w_ff[14][18:0], w_ff[14][31:19]}
           ^ (w_ff[14] >> 10);
      w_new = w_ff[0] + sg0 + w_ff[9] + sg1;
      big1 = {e_ff[5:0], e_ff[31:6]} ^ {e_ff[10:0], e_ff[31:11]} ^ {e_ff[24:0], e_ff[31:25]};
      chs  = (e_ff & f_ff) ^ (~e_ff & g_ff);
      big0 = {a_ff[1:0], a_ff[31:2]} ^ {a_ff[12:0], a_ff[31:13]} ^ {a_ff[21:0], a_ff[31:22]};
      maj  = (a_ff & b_ff) ^ (a_ff & c_ff) ^ (b_ff & c_ff);
      t1   = h_ff + big1 + chs + round_const(round_ff) + w_ff[0];
      t2   = big0 + maj;
   end

   always_comb begin
      w_in = w_ff;
      hash_in = hash_ff;
      {a_in, b_in, c_in, d_in, e_in, f_in, g_in, h_in} =
         {a_ff, b_ff, c_ff, d_ff, e_ff, f_ff, g_ff, h_ff};
      fill_in  = fill_ff;
      round_in = round_ff;
      bits_in  = bits_ff;
      len_in   = len_ff;
      if (cmd.count_bits) bits_in = bits_ff + 64'd8;
      if (cmd.put_byte) begin
         w_in[fill_ff[5:2]] = (w_ff[fill_ff[5:2]] << 8) | {24'd0, byte_val};
         fill_in = fill_ff + 7'd1;
         if (cmd.src == SRC_PAD80) len_in = bits_ff;
         if (cmd.src == SRC_LEN) len_in = {len_ff[55:0], 8'd0};
      end
      if (cmd.start_comp) begin
         {a_in, b_in, c_in, d_in} = {hash_ff[0], hash_ff[1], hash_ff[2], hash_ff[3]};
         {e_in, f_in, g_in, h_in} = {hash_ff[4], hash_ff[5], hash_ff[6], hash_ff[7]};
         round_in = '0;
         fill_in  = '0;
      end
      if (cmd.round_step) begin
         for (int i = 0; i < 15; i++) w_in[i] = w_ff[i + 1];
         w_in[15] = w_new;
         h_in = g_ff; g_in = f_ff; f_in = e_ff; e_in = d_ff + t1;
         d_in = c_ff; c_in = b_ff; b_in = a_ff; a_in = t1 + t2;
         round_in = round_ff + 6'd1;
      end
      if (cmd.add_hash) begin
         hash_in[0] = hash_ff[0] + a_ff; hash_in[1] = hash_ff[1] + b_ff;
         hash_in[2] = hash_ff[2] + c_ff; hash_in[3] = hash_ff[3] + d_ff;
         hash_in[4] = hash_ff[4] + e_ff; hash_in[5] = hash_ff[5] + f_ff;
         hash_in[6] = hash_ff[6] + g_ff; hash_in[7] = hash_ff[7] + h_ff;
      end
      if (cmd.emit_shift) begin
         for (int i = 0; i < 7; i++) hash_in[i] = hash_ff[i + 1];
         hash_in[7] = hash_ff[0];
      end
      if (cmd.restore_iv) begin
         for (int i = 0; i < 8; i++) hash_in[i] = iv_word(3'(i));
         bits_in = '0;
         fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) hash_ff[i] <= iv_word(3'(i));
         fill_ff <= '0;
         bits_ff <= '0;
         round_ff <= '0;
      end else begin
         hash_ff <= hash_in;
         fill_ff <= fill_in;
         bits_ff <= bits_in;
         round_ff <= round_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
      {a_ff, b_ff, c_ff, d_ff, e_ff, f_ff, g_ff, h_ff} <=
         {a_in, b_in, c_in, d_in, e_in, f_in, g_in, h_in};
      len_ff <= len_in;
   end

   assign status = '{fill: fill_ff, round_last: (round_ff == 6'(Rounds - 1))};
   assign digest_word = hash_ff[0];
endmodule
`default_nettype wire

FILE: design/sha256_ctrl.sv
// Controller: absorb, padding, compression and digest emission sequencing.
`default_nettype none
module sha256_ctrl (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_tvalid,
   output logic                       req_tready,
   input  wire                        req_cmd,
   output logic                       rsp_tvalid,
   input  wire                        rsp_tready,
   output logic [2:0]                 rsp_index,
   input  sha256_pkg::dp_status_type  status,
   output sha256_pkg::dp_cmd_type     cmd
);
   import sha256_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic       finishing_ff, finishing_in;
   logic [2:0] idx_ff, idx_in;
   // 0x80 landed in the length field: length goes into a further block
   logic       extra_ff, extra_in;
   // length bytes written means the final block went through
   logic       lenDone_ff, lenDone_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         finishing_ff <= 1'b0;
         idx_ff <= '0;
         extra_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         finishing_ff <= finishing_in;
         idx_ff <= idx_in;
         extra_ff <= extra_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      finishing_in = finishing_ff;
      idx_in = idx_ff;
      extra_in = extra_ff;
      cmd = '0;
      cmd.src = SRC_DATA;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_cmd) begin
                  cmd.put_byte = 1'b1;
                  cmd.src = SRC_PAD80;
                  finishing_in = 1'b1;
                  extra_in = (status.fill >= 7'd56);
                  state_in = (status.fill == 7'd63) ? ST_COMPRESS : ST_PAD;
               end else begin
                  cmd.put_byte = 1'b1;
                  cmd.count_bits = 1'b1;
                  if (status.fill == 7'd63) state_in = ST_COMPRESS;
               end
            end
         end
         ST_PAD: begin
            cmd.put_byte = 1'b1;
            cmd.src = (status.fill >= 7'd56) && finishing_ff && !extra_ff ? SRC_LEN : SRC_ZERO;
            if (status.fill == 7'd63) state_in = ST_COMPRESS;
         end
         ST_COMPRESS: begin
            if (status.fill != 7'd0) begin
               cmd.start_comp = 1'b1;
            end else begin
               cmd.round_step = 1'b1;
               if (status.round_last) state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            cmd.add_hash = 1'b1;
            extra_in = 1'b0;
            state_in = ST_IDLE;
            if (finishing_ff) state_in = ST_PAD;
         end
         ST_EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               cmd.emit_shift = 1'b1;
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  cmd.emit_shift = 1'b0;
                  cmd.restore_iv = 1'b1;
                  finishing_in = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (state_ff == ST_ADD && finishing_ff && lenDone_ff) begin
         state_in = ST_EMIT;
         idx_in = '0;
      end
   end

   always_comb begin
      lenDone_in = lenDone_ff;
      if (cmd.put_byte && cmd.src == SRC_LEN) lenDone_in = 1'b1;
      if (cmd.restore_iv) lenDone_in = 1'b0;
   end
   always_ff @(posedge clock) begin
      if (reset) lenDone_ff <= 1'b0;
      else lenDone_ff <= lenDone_in;
   end

   assign rsp_index = idx_ff;
endmodule
`default_nettype wire

FILE: design/sha256_hash_core.sv
// Top level: streaming SHA-256 core.
// Absorb transaction: one byte; every 64th byte adds a block compression (1 round/cycle).
// Finish transaction: pads byte-serially (9 to 72 bytes, 1 byte/cycle), compresses one or
// two blocks, then emits eight digest words, one per cycle while rsp_tready is high.
// Absorb requests are not accepted while a block compresses on the single round unit.
// Synchronous active-high reset restores the initial hash values and clears the counts.
`default_nettype none
module sha256_hash_core (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // data_byte[7:0]
   input  wire         req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata,   // digest_word[31:0], word_index[34:32], zero fill
   output logic        rsp_tlast    // last_word
);
   import sha256_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic [31:0]   digest_word;
   logic [2:0]    idx;

   sha256_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_cmd(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_index(idx),
      .status(status), .cmd(cmd)
   );

   sha256_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .data_byte(req_tdata),
      .status(status), .digest_word(digest_word)
   );

   assign rsp_tdata = {5'd0, idx, digest_word};
   assign rsp_tlast = (idx == 3'd7);
endmodule
`default_nettype wire

FILE: tb/tb_sha256_hash_core.sv
// Testbench for sha256_hash_core: byte stream in, digests predicted and compared per word.
`timescale 1ns / 1ps
`default_nettype none
module tb_sha256_hash_core;
   localparam logic CMD_ABSORB = 1'b0;
   localparam logic CMD_FINISH = 1'b1;
   localparam int unsigned CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic       cmd;
      logic [7:0] data_byte;
   } req_item_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } digest_item_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;

   sha256_hash_core uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   req_item_type    pending_q[$];
   digest_item_type digest_q[$];
   int unsigned  errors;
   int unsigned  cycles;
   int unsigned  bytes_sent;
   int unsigned  digests_seen;
   int unsigned  words_seen;
   bit           hold_rsp;
   bit           pause_tx;
   bit           req_taken;
   int unsigned  burst_left;
   int unsigned  gap_left;
   int unsigned  stall_left;

   // predictor state
   logic [31:0] h_state [0:7];
   logic [7:0]  blk [0:63];
   logic [6:0]  fill;
   logic [63:0] msg_bits;

   function automatic logic [31:0] rotr(input logic [31:0] v, input int k);
      return (v >> k) | (v << (32 - k));
   endfunction

   task automatic load_iv();
      for (int i = 0; i < 8; i++) h_state[i] = sha256_pkg::iv_word(i[2:0]);
      fill = '0;
      msg_bits = '0;
   endtask

   task automatic compress_block();
      logic [31:0] w [0:63];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      for (int r = 0; r < 16; r++)
         w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
      for (int r = 16; r < 64; r++) begin
         s0 = rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3);
         s1 = rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10);
         w[r] = w[r-16] + s0 + w[r-7] + s1;
      end
      a = h_state[0]; b = h_state[1]; c = h_state[2]; d = h_state[3];
      e = h_state[4]; f = h_state[5]; g = h_state[6]; h = h_state[7];
      for (int r = 0; r < 64; r++) begin
         t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
            + sha256_pkg::round_const(r[5:0]) + w[r];
         t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      h_state[0] += a; h_state[1] += b; h_state[2] += c; h_state[3] += d;
      h_state[4] += e; h_state[5] += f; h_state[6] += g; h_state[7] += h;
   endtask

   task automatic append_byte(input logic [7:0] v);
      blk[fill[5:0]] = v;
      fill = fill + 7'd1;
      if (fill >= 7'd64) begin
         compress_block();
         fill = '0;
      end
   endtask

   task automatic predict_digest(input req_item_type it);
      logic [63:0] total;
      digest_item_type d;
      if (it.cmd == CMD_ABSORB) begin
         msg_bits = msg_bits + 64'd8;
         append_byte(it.data_byte);
      end else begin
         total = msg_bits;
         append_byte(8'h80);
         while (fill != 7'd56) append_byte(8'h00);
         for (int k = 0; k < 8; k++) append_byte(total[63-8*k -: 8]);
         for (int k = 0; k < 8; k++) begin
            d.digest_word = h_state[k];
            d.word_index = k[2:0];
            d.last_word = (k == 7);
            digest_q = {digest_q, d};
         end
         load_iv();
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] exp);
      $display("MISMATCH t=%0t %s got %h exp %h", $time, what, got, exp);
      errors++;
   endtask

   task automatic queue_message(input int unsigned len, input int kind);
      req_item_type it;
      for (int unsigned i = 0; i < len; i++) begin
         it.cmd = CMD_ABSORB;
         case (kind)
            1: it.data_byte = 8'h00;
            2: it.data_byte = 8'hff;
            default: it.data_byte = 8'($urandom_range(0, 255));
         endcase
         pending_q = {pending_q, it};
      end
      it.cmd = CMD_FINISH;
      it.data_byte = 8'($urandom_range(0, 255));
      pending_q = {pending_q, it};
   endtask

   always begin
      clock = 1'b1; #10;
      clock = 1'b0; #10;
   end

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= 8'h00;
         req_tuser <= CMD_ABSORB;
         burst_left <= 0;
         gap_left <= 0;
      end else if (req_tvalid && !req_taken) begin
         // hold the offered transaction
      end else if (pause_tx || pending_q.size() == 0) begin
         req_tvalid <= 1'b0;
      end else if (gap_left > 0) begin
         req_tvalid <= 1'b0;
         gap_left <= gap_left - 1;
      end else begin
         req_tvalid <= 1'b1;
         req_tdata <= pending_q[0].data_byte;
         req_tuser <= pending_q[0].cmd;
         if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
         end else begin
            burst_left <= burst_left - 1;
         end
      end
   end

   // sampling of request handshakes
   always @(posedge clock) begin
      req_item_type it;
      req_taken = !reset && req_tvalid && req_tready;
      if (req_taken) begin
         it = pending_q.pop_front();
         predict_digest(it);
         if (it.cmd == CMD_FINISH) digests_seen++;
         else bytes_sent++;
      end
   end

   // receiver stall pattern
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (hold_rsp) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 8);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor
   always @(posedge clock) begin
      digest_item_type exp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         words_seen++;
         if (digest_q.size() == 0) begin
            report_mismatch("unexpected word", rsp_tdata[31:0], 32'h0);
         end else begin
            exp = digest_q.pop_front();
            if (rsp_tdata[31:0] !== exp.digest_word)
               report_mismatch("digest_word", rsp_tdata[31:0], exp.digest_word);
            if (rsp_tdata[34:32] !== exp.word_index)
               report_mismatch("word_index", {29'd0, rsp_tdata[34:32]},
                               {29'd0, exp.word_index});
            if (rsp_tlast !== exp.last_word)
               report_mismatch("last_word", {31'd0, rsp_tlast}, {31'd0, exp.last_word});
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      int unsigned lens [0:4];
      int unsigned held;
      lens = '{0, 55, 56, 63, 64};
      hold_rsp = 0;
      pause_tx = 0;
      reset = 1'b1;
      load_iv();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty message, padding boundaries, all-zero and all-ones bytes
      for (int i = 0; i < 5; i++) queue_message(lens[i], i % 3);

      // long receiver hold-off while the sender keeps offering
      hold_rsp = 1;
      held = 0;
      while (held < 600) begin
         @(posedge clock);
         held++;
      end
      hold_rsp = 0;

      // sender pause until every digest has drained
      wait (pending_q.size() == 0);
      pause_tx = 1;
      wait (digest_q.size() == 0);
      repeat (5) @(posedge clock);
      pause_tx = 0;

      // a couple of short random messages
      for (int i = 0; i < 2; i++)
         queue_message($urandom_range(0, 12), $urandom_range(0, 9) == 0 ? 2 : 0);

      wait (pending_q.size() == 0);
      wait (digest_q.size() == 0);
      repeat (300) @(posedge clock);
      $display("covered %0d message bytes and %0d digests, %0d words checked",
               bytes_sent, digests_seen, words_seen);
      $display("lengths across padding boundaries, receiver hold-off and drain pause");
      if (errors == 0 && digest_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
